/* sv/fvn_pkg.sv */
// Shared types, constants and the reciprocal table for the fractal value noise block.
package fvn_pkg;

	typedef logic [31:0] word_t;
	typedef logic [63:0] dword_t;

	localparam int DEF_MAX_OCTAVES = 8;
	localparam int DEF_FRAC_BITS   = 16;
	localparam int POS_W           = 46;
	localparam int NOISE_W         = 24;

	localparam word_t PCG1_MUL  = 32'd747796405;
	localparam word_t PCG1_INC  = 32'd2891336453;
	localparam word_t PCG1_MIX  = 32'd277803737;
	localparam word_t LCG_MUL   = 32'd1664525;
	localparam word_t LCG_INC   = 32'd1013904223;
	localparam word_t SEED_STEP = 32'd7919;
	localparam word_t LAT_BIAS  = 32'd1024;
	localparam int    SCALE_Q16 = 132383;

	// Floor of 2^24 / (2^n - 1) for octave counts from 1 to 16.
	function automatic logic [24:0] fvn_recip(input logic [4:0] n);
		logic [24:0] r;
		unique case (n)
			5'd1:  r = 25'd16777216;
			5'd2:  r = 25'd5592405;
			5'd3:  r = 25'd2396745;
			5'd4:  r = 25'd1118481;
			5'd5:  r = 25'd541200;
			5'd6:  r = 25'd266305;
			5'd7:  r = 25'd132104;
			5'd8:  r = 25'd65793;
			5'd9:  r = 25'd32832;
			5'd10: r = 25'd16400;
			5'd11: r = 25'd8196;
			5'd12: r = 25'd4097;
			5'd13: r = 25'd2048;
			5'd14: r = 25'd1024;
			5'd15: r = 25'd512;
			5'd16: r = 25'd256;
			default: r = 25'd16777216;
		endcase
		return r;
	endfunction

endpackage

/* sv/fvn_mac.sv */
// Shared 32x32 multiply-add unit for the hash, weight, blend and final steps.
module fvn_mac (
	input  fvn_pkg::word_t  a,
	input  fvn_pkg::word_t  b,
	input  fvn_pkg::dword_t c,
	output fvn_pkg::dword_t p
);
	import fvn_pkg::*;

	dword_t prod;

	assign prod = 64'(a) * 64'(b);
	assign p    = prod + c;

endmodule

/* sv/fractal_value_noise.sv */
// Top level of the fractal value noise block: sequencer, state registers and output register.
//
// Input channel: pos_x, pos_y, pos_z (signed fixed point), seed and octave_count move in one
// beat under in_valid / in_ready. Output channel: one noise beat per input beat under
// out_valid / out_ready, an unsigned Q0.24 fraction.
// One item is worked through a single shared 32x32 multiply-add unit. Each octave computes
// the axis offsets, then the lattice bases and smoothstep weights, then the eight corner hashes
// (7 multiplies each), the trilinear blend and the accumulation. Between octaves the
// positions are scaled and the seed is stepped.
// The block takes one item at a time; in_ready is high only while no item is in work.
// The result sits in an output register, so a new item is accepted while it waits; the
// next result is held back until the waiting one has been taken.
// Reset clears the sequencer and the output valid flag; no item or result survives it.
module fractal_value_noise #(
	parameter int MAX_OCTAVES = fvn_pkg::DEF_MAX_OCTAVES,
	parameter int FRAC_BITS   = fvn_pkg::DEF_FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  pos_x,
	input  logic signed [31:0]  pos_y,
	input  logic signed [31:0]  pos_z,
	input  logic        [31:0]  seed,
	input  logic        [3:0]   octave_count,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [fvn_pkg::NOISE_W-1:0] noise
);
	import fvn_pkg::*;

	localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
	localparam int ACC_W = NOISE_W + MAX_OCTAVES;
	localparam int ONE   = 2 ** FRAC_BITS;
	localparam logic [FRAC_BITS+1:0] THREE_ONE = (FRAC_BITS + 2)'(3 * ONE);
	localparam logic [FRAC_BITS:0]   ONE_W     = (FRAC_BITS + 1)'(ONE);
	localparam logic signed [63:0] POS_MAX = 64'sd35184372088831;
	localparam logic signed [63:0] POS_MIN = -64'sd35184372088832;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_OFF1 = 4'd1;
	localparam logic [3:0] ST_OFF2 = 4'd2;
	localparam logic [3:0] ST_BASE = 4'd3;
	localparam logic [3:0] ST_SM1  = 4'd4;
	localparam logic [3:0] ST_SM2  = 4'd5;
	localparam logic [3:0] ST_HASH = 4'd6;
	localparam logic [3:0] ST_LR1  = 4'd7;
	localparam logic [3:0] ST_LR2  = 4'd8;
	localparam logic [3:0] ST_ACC  = 4'd9;
	localparam logic [3:0] ST_SC   = 4'd10;
	localparam logic [3:0] ST_FIN1 = 4'd11;
	localparam logic [3:0] ST_FIN2 = 4'd12;

	logic [3:0]       state_q;
	logic [1:0]       ax_q;
	logic [2:0]       step_q;
	logic [2:0]       k_q;
	logic [2:0]       lr_q;
	logic [OCT_W-1:0] oct_q;
	logic [OCT_W-1:0] n_q;
	logic             out_valid_q;

	logic signed [POS_W-1:0] pos_q [3];
	word_t                   seed_q;
	word_t                   off_y_q;
	word_t                   off_z_q;
	word_t                   h0_q;
	word_t                   base_q [3];
	logic [FRAC_BITS-1:0]    f2_q;
	logic [FRAC_BITS:0]      w_q [3];
	word_t                   hx_q;
	word_t                   hy_q;
	word_t                   hz_q;
	logic [NOISE_W-1:0]      c_q [8];
	dword_t                  t_q;
	logic [ACC_W-1:0]        acc_q;
	logic [NOISE_W-1:0]      noise_q;

	word_t                   mac_a;
	word_t                   mac_b;
	dword_t                  mac_c;
	dword_t                  mac_p;
	logic [63:0]             pos64;
	logic [FRAC_BITS-1:0]    frac;
	logic [FRAC_BITS:0]      w_sel;
	word_t                   corner_x;
	word_t                   corner_y;
	word_t                   corner_z;
	word_t                   mix_x;
	word_t                   mix_y;
	word_t                   mix_z;
	word_t                   off_sel;
	logic [4:0]              pcg_sh;
	logic [24:0]             recip;
	dword_t                  acc64;
	dword_t                  fin_sum;
	logic signed [63:0]      sc_prod;
	logic signed [63:0]      sc_q;
	logic signed [POS_W-1:0] sc_sat;
	logic [OCT_W-1:0]        n_in;
	logic [OCT_W-1:0]        acc_sh;
	logic                    out_load;
	logic                    last_oct;

	fvn_mac u_mac (
		.a(mac_a),
		.b(mac_b),
		.c(mac_c),
		.p(mac_p)
	);

	assign pos64    = {{(64 - POS_W){pos_q[ax_q][POS_W-1]}}, pos_q[ax_q]};
	assign frac     = pos_q[ax_q][FRAC_BITS-1:0];
	assign w_sel    = (lr_q < 3'd4) ? w_q[0] : ((lr_q < 3'd6) ? w_q[1] : w_q[2]);
	assign corner_x = base_q[0] + {31'b0, k_q[0]};
	assign corner_y = base_q[1] + {31'b0, k_q[1]};
	assign corner_z = base_q[2] + {31'b0, k_q[2]};
	assign mix_x    = hx_q ^ (hx_q >> 16);
	assign mix_y    = hy_q ^ (hy_q >> 16);
	assign mix_z    = hz_q ^ (hz_q >> 16);
	assign pcg_sh   = 5'(h0_q[31:28]) + 5'd4;
	assign recip    = fvn_recip(5'(n_q));
	assign acc64    = 64'(acc_q);
	assign fin_sum  = t_q + {mac_p[31:0], 32'b0};
	assign sc_prod  = 64'(pos_q[ax_q]) * 64'sd132383;
	assign sc_q     = sc_prod >>> 16;
	assign sc_sat   = (sc_q > POS_MAX) ? POS_MAX[POS_W-1:0] :
	                  ((sc_q < POS_MIN) ? POS_MIN[POS_W-1:0] : sc_q[POS_W-1:0]);
	assign acc_sh   = n_q - oct_q - OCT_W'(1);
	assign out_load = !out_valid_q || out_ready;
	assign last_oct = (oct_q == n_q - OCT_W'(1));

	always_comb begin
		if (octave_count == 4'd0) begin
			n_in = OCT_W'(1);
		end else if (32'(octave_count) > MAX_OCTAVES) begin
			n_in = OCT_W'(MAX_OCTAVES);
		end else begin
			n_in = OCT_W'(octave_count);
		end
	end

	always_comb begin
		unique case (ax_q)
			2'd1:    off_sel = off_y_q;
			2'd2:    off_sel = off_z_q;
			default: off_sel = seed_q;
		endcase
	end

	always_comb begin
		mac_a = '0;
		mac_b = '0;
		mac_c = '0;
		unique case (state_q)
			ST_OFF1: begin
				mac_a = seed_q + {31'b0, ax_q[1]};
				mac_b = PCG1_MUL;
				mac_c = 64'(PCG1_INC);
			end
			ST_OFF2: begin
				mac_a = (h0_q >> pcg_sh) ^ h0_q;
				mac_b = PCG1_MIX;
			end
			ST_SM1: begin
				mac_a = 32'(frac);
				mac_b = 32'(frac);
			end
			ST_SM2: begin
				mac_a = 32'(f2_q);
				mac_b = 32'(THREE_ONE - (FRAC_BITS + 2)'({frac, 1'b0}));
			end
			ST_HASH: begin
				unique case (step_q)
					3'd0: begin
						mac_a = corner_x;
						mac_b = LCG_MUL;
						mac_c = 64'(LCG_INC);
					end
					3'd1: begin
						mac_a = corner_y;
						mac_b = LCG_MUL;
						mac_c = 64'(LCG_INC);
					end
					3'd2: begin
						mac_a = corner_z;
						mac_b = LCG_MUL;
						mac_c = 64'(LCG_INC);
					end
					3'd3: begin
						mac_a = hy_q;
						mac_b = hz_q;
						mac_c = 64'(hx_q);
					end
					3'd4: begin
						mac_a = hz_q;
						mac_b = hx_q;
						mac_c = 64'(hy_q);
					end
					3'd5: begin
						mac_a = hx_q;
						mac_b = hy_q;
						mac_c = 64'(hz_q);
					end
					default: begin
						mac_a = mix_y;
						mac_b = mix_z;
						mac_c = 64'(mix_x);
					end
				endcase
			end
			ST_LR1: begin
				mac_a = 32'(c_q[0]);
				mac_b = 32'(ONE_W - w_sel);
			end
			ST_LR2: begin
				mac_a = 32'(c_q[1]);
				mac_b = 32'(w_sel);
				mac_c = t_q;
			end
			ST_FIN1: begin
				mac_a = acc64[31:0];
				mac_b = 32'(recip);
			end
			ST_FIN2: begin
				mac_a = acc64[63:32];
				mac_b = 32'(recip);
			end
			default: begin
				mac_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ax_q        <= '0;
			step_q      <= '0;
			k_q         <= '0;
			lr_q        <= '0;
			oct_q       <= '0;
			n_q         <= OCT_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN2 && out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						n_q     <= n_in;
						oct_q   <= '0;
						ax_q    <= 2'd1;
						state_q <= ST_OFF1;
					end
				end
				ST_OFF1: state_q <= ST_OFF2;
				ST_OFF2: begin
					if (ax_q == 2'd2) begin
						ax_q    <= 2'd0;
						state_q <= ST_BASE;
					end else begin
						ax_q    <= 2'd2;
						state_q <= ST_OFF1;
					end
				end
				ST_BASE: state_q <= ST_SM1;
				ST_SM1:  state_q <= ST_SM2;
				ST_SM2: begin
					if (ax_q == 2'd2) begin
						ax_q    <= 2'd0;
						step_q  <= '0;
						k_q     <= '0;
						state_q <= ST_HASH;
					end else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= ST_BASE;
					end
				end
				ST_HASH: begin
					if (step_q == 3'd6) begin
						step_q <= '0;
						k_q    <= k_q + 3'd1;
						if (k_q == 3'd7) begin
							lr_q    <= '0;
							state_q <= ST_LR1;
						end
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				ST_LR1: state_q <= ST_LR2;
				ST_LR2: begin
					lr_q <= lr_q + 3'd1;
					if (lr_q == 3'd6) begin
						state_q <= ST_ACC;
					end else begin
						state_q <= ST_LR1;
					end
				end
				ST_ACC: begin
					ax_q <= 2'd0;
					if (last_oct) begin
						state_q <= ST_FIN1;
					end else begin
						state_q <= ST_SC;
					end
				end
				ST_SC: begin
					if (ax_q == 2'd2) begin
						ax_q    <= 2'd1;
						oct_q   <= oct_q + OCT_W'(1);
						state_q <= ST_OFF1;
					end else begin
						ax_q <= ax_q + 2'd1;
					end
				end
				ST_FIN1: state_q <= ST_FIN2;
				ST_FIN2: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					pos_q[0] <= POS_W'(pos_x);
					pos_q[1] <= POS_W'(pos_y);
					pos_q[2] <= POS_W'(pos_z);
					seed_q   <= seed;
					acc_q    <= '0;
				end
			end
			ST_OFF1: h0_q <= mac_p[31:0];
			ST_OFF2: begin
				if (ax_q == 2'd2) begin
					off_z_q <= mac_p[31:0] ^ (mac_p[31:0] >> 22);
				end else begin
					off_y_q <= mac_p[31:0] ^ (mac_p[31:0] >> 22);
				end
			end
			ST_BASE: base_q[ax_q] <= pos64[FRAC_BITS +: 32] + LAT_BIAS + off_sel;
			ST_SM1:  f2_q <= mac_p[FRAC_BITS +: FRAC_BITS];
			ST_SM2:  w_q[ax_q] <= mac_p[FRAC_BITS +: FRAC_BITS + 1];
			ST_HASH: begin
				unique case (step_q)
					3'd0, 3'd3: hx_q <= mac_p[31:0];
					3'd1, 3'd4: hy_q <= mac_p[31:0];
					3'd2, 3'd5: hz_q <= mac_p[31:0];
					default:    c_q[k_q] <= mac_p[31:8];
				endcase
			end
			ST_LR1: t_q <= mac_p;
			ST_LR2: begin
				for (int i = 0; i < 6; i++) begin
					if (3'(i) == 3'd6 - lr_q) begin
						c_q[i] <= mac_p[FRAC_BITS +: NOISE_W];
					end else begin
						c_q[i] <= c_q[i + 2];
					end
				end
				if (lr_q == 3'd0) begin
					c_q[6] <= mac_p[FRAC_BITS +: NOISE_W];
				end
			end
			ST_ACC: acc_q <= acc_q + (ACC_W'(c_q[0]) << acc_sh);
			ST_SC: begin
				pos_q[ax_q] <= sc_sat;
				if (ax_q == 2'd2) begin
					seed_q <= seed_q + SEED_STEP;
				end
			end
			ST_FIN1: t_q <= mac_p;
			ST_FIN2: begin
				if (out_load) begin
					noise_q <= fin_sum[47:24];
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign noise     = noise_q;

`ifndef SYNTHESIS
	a_oct_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (oct_q < n_q))
		else $error("Octave counter ran past the octave count.");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_OFF1 && oct_q == '0 && ax_q == 2'd1))
		else $error("Accepted beat did not start the offset hash of octave zero.");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN2 && out_load) |=> (out_valid && state_q == ST_IDLE))
		else $error("Finished item did not reach the output register.");

	a_blend_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (lr_q == 3'd7 && $past(state_q) == ST_LR2))
		else $error("Accumulation started before all seven blends were done.");
`endif

endmodule
